// ===== src/wpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared constants and controller/datapath types for the WAV PCM16 parser.
// ----------------------------------------------------------------------------
package wpd_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int NUM_W            = 32;

  localparam logic [3:0] PH_RIFF  = 4'd0;
  localparam logic [3:0] PH_SIZE  = 4'd1;
  localparam logic [3:0] PH_WAVE  = 4'd2;
  localparam logic [3:0] PH_ID    = 4'd3;
  localparam logic [3:0] PH_CSIZE = 4'd4;
  localparam logic [3:0] PH_FMT   = 4'd5;
  localparam logic [3:0] PH_SKIP  = 4'd6;
  localparam logic [3:0] PH_DATA  = 4'd7;
  localparam logic [3:0] PH_HALT  = 4'd8;
  localparam logic [3:0] PH_DONE  = 4'd9;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [2:0] ERR_NO_RIFF   = 3'd0;
  localparam logic [2:0] ERR_NO_WAVE   = 3'd1;
  localparam logic [2:0] ERR_NOT_PCM   = 3'd2;
  localparam logic [2:0] ERR_MISSING   = 3'd3;
  localparam logic [2:0] ERR_NOT_16BIT = 3'd4;
  localparam logic [2:0] ERR_ZERO_CH   = 3'd5;
  localparam logic [2:0] ERR_TRUNC     = 3'd6;
  localparam logic [2:0] ERR_MANY_CH   = 3'd7;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic [15:0] FMT_PCM     = 16'd1;
  localparam logic [15:0] BITS_16     = 16'd16;
  localparam logic [31:0] FMT_FIELD_N = 32'd16;

  typedef struct packed {
    logic step;
    logic div_start;
    logic load_q;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic have;
    logic div_done;
  } status_t;

endpackage
`default_nettype wire

// ===== src/wpd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpd_div #(
  parameter int DEN_W = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [wpd_pkg::NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0]         den,
  output logic      [wpd_pkg::NUM_W-1:0] quo,
  output logic                          done
);

  localparam int NW  = wpd_pkg::NUM_W;
  localparam int CW  = $clog2(NW + 1);

  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [NW-1:0]    q_r, q_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   trial;

  always_comb begin
    trial   = {rem_r[DEN_W-1:0], q_r[NW-1]};
    q_nxt   = {q_r[NW-2:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, den_r}) begin
      rem_nxt  = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== src/wpd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_ctrl
// Handshake sequencer: accept, step, divide, hand off to the output register.
// ----------------------------------------------------------------------------
module wpd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire wpd_pkg::status_t sts,
  output wpd_pkg::cmd_t         cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       out_free;

  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_STEP;
      end
      ST_STEP: begin
        cmd.step = 1'b1;
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.load_q = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!sts.have) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_tready) ovalid_nxt = 1'b0;
    if (cmd.load_out) ovalid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;

endmodule
`default_nettype wire

// ===== src/wpd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpd_datapath
// RIFF/WAVE parse state, channel accumulation, result and output registers.
// ----------------------------------------------------------------------------
module wpd_datapath #(
  parameter int MAX_CHANNELS = wpd_pkg::MAX_CHANNELS_DEF,
  parameter int DEN_W        = $clog2(MAX_CHANNELS) + 2
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_accept,
  input  wire logic [7:0]                in_byte,
  input  wire logic                      in_eof,
  input  wire wpd_pkg::cmd_t             cmd,
  output logic                           need_div,
  output logic                           have,
  output logic [wpd_pkg::NUM_W-1:0]      div_num,
  output logic [DEN_W-1:0]               div_den,
  input  wire logic [wpd_pkg::NUM_W-1:0] div_quo,
  output logic [1:0]                     o_kind,
  output logic [15:0]                    o_mono,
  output logic [31:0]                    o_rate,
  output logic [15:0]                    o_ch,
  output logic [30:0]                    o_frames,
  output logic [2:0]                     o_err,
  output logic                           o_final
);

  localparam int SUM_W = 16 + $clog2(MAX_CHANNELS) + 1;

  logic [7:0]  byte_r;
  logic        eof_r;

  logic [3:0]  ph_r, ph_nxt;
  logic [4:0]  fbc_r, fbc_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] chunk_r, chunk_nxt;
  logic [15:0] fmt_r, fmt_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic        found_r, found_nxt;
  logic [31:0] dleft_r, dleft_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [7:0]  low_r, low_nxt;

  logic        have_r, sel_frames_r, neg_r;
  logic [1:0]  kind_r;
  logic [15:0] mono_r;
  logic [31:0] rate_res_r;
  logic [15:0] ch_res_r;
  logic [30:0] frames_r;
  logic [2:0]  err_r;
  logic        final_r;

  logic        c_have, c_iserr, c_div, c_neg, c_sel_frames, c_final;
  logic [1:0]  c_kind;
  logic [2:0]  c_err;
  logic [31:0] c_rate;
  logic [15:0] c_ch;
  logic [31:0] c_num;
  logic [DEN_W-1:0] c_den;
  logic [4:0]  fbc_inc;
  logic [2:0]  code;
  logic        code_ok;
  logic signed [SUM_W-1:0] sum_new;
  logic signed [SUM_W-1:0] sum_mag;
  logic [15:0] idx_new;

  assign fbc_inc = fbc_r + 5'd1;

  always_comb begin
    ph_nxt = ph_r; fbc_nxt = fbc_r; tag_nxt = tag_r; chunk_nxt = chunk_r;
    fmt_nxt = fmt_r; ch_nxt = ch_r; rate_nxt = rate_r; bits_nxt = bits_r;
    found_nxt = found_r; dleft_nxt = dleft_r; idx_nxt = idx_r; sum_nxt = sum_r;
    low_nxt = low_r;
    c_have = 1'b0; c_iserr = 1'b0; c_div = 1'b0; c_neg = 1'b0;
    c_sel_frames = 1'b0; c_final = 1'b0; c_kind = wpd_pkg::KIND_SAMPLE;
    c_err = '0; c_rate = '0; c_ch = '0; c_num = '0; c_den = '0;
    code = '0; code_ok = 1'b0;
    sum_new = sum_r + SUM_W'($signed({byte_r, low_r}));
    sum_mag = sum_new[SUM_W-1] ? -sum_new : sum_new;
    idx_new = idx_r + 16'd1;
    case (ph_r)
      wpd_pkg::PH_RIFF, wpd_pkg::PH_WAVE, wpd_pkg::PH_ID: begin
        tag_nxt = {tag_r[23:0], byte_r};
        fbc_nxt = fbc_inc;
        if (fbc_inc >= 5'd4) begin
          fbc_nxt = '0;
          if (ph_r == wpd_pkg::PH_ID) begin
            chunk_nxt = '0;
            ph_nxt    = wpd_pkg::PH_CSIZE;
          end else if (ph_r == wpd_pkg::PH_RIFF) begin
            if (tag_nxt != wpd_pkg::TAG_RIFF) begin
              c_kind = wpd_pkg::KIND_ERROR; c_err = wpd_pkg::ERR_NO_RIFF;
              c_have = 1'b1; c_iserr = 1'b1; ph_nxt = wpd_pkg::PH_HALT;
            end else begin
              ph_nxt = wpd_pkg::PH_SIZE;
            end
          end else begin
            if (tag_nxt != wpd_pkg::TAG_WAVE) begin
              c_kind = wpd_pkg::KIND_ERROR; c_err = wpd_pkg::ERR_NO_WAVE;
              c_have = 1'b1; c_iserr = 1'b1; ph_nxt = wpd_pkg::PH_HALT;
            end else begin
              ph_nxt = wpd_pkg::PH_ID;
            end
          end
        end
      end
      wpd_pkg::PH_SIZE: begin
        fbc_nxt = fbc_inc;
        if (fbc_inc >= 5'd4) begin
          fbc_nxt = '0;
          ph_nxt  = wpd_pkg::PH_WAVE;
        end
      end
      wpd_pkg::PH_CSIZE: begin
        case (fbc_r[1:0])
          2'd0:    chunk_nxt[7:0]   = chunk_r[7:0]   | byte_r;
          2'd1:    chunk_nxt[15:8]  = chunk_r[15:8]  | byte_r;
          2'd2:    chunk_nxt[23:16] = chunk_r[23:16] | byte_r;
          default: chunk_nxt[31:24] = chunk_r[31:24] | byte_r;
        endcase
        fbc_nxt = fbc_inc;
        if (fbc_inc >= 5'd4) begin
          fbc_nxt = '0;
          if (tag_r == wpd_pkg::TAG_FMT) begin
            fmt_nxt = '0; ch_nxt = '0; rate_nxt = '0; bits_nxt = '0;
            ph_nxt  = wpd_pkg::PH_FMT;
          end else if (tag_r == wpd_pkg::TAG_DATA) begin
            if (!found_r) begin
              code = wpd_pkg::ERR_MISSING; code_ok = 1'b1;
            end else if (bits_r != wpd_pkg::BITS_16) begin
              code = wpd_pkg::ERR_NOT_16BIT; code_ok = 1'b1;
            end else if (ch_r == 16'd0) begin
              code = wpd_pkg::ERR_ZERO_CH; code_ok = 1'b1;
            end else if (ch_r > 16'(MAX_CHANNELS)) begin
              code = wpd_pkg::ERR_MANY_CH; code_ok = 1'b1;
            end
            if (code_ok) begin
              c_kind = wpd_pkg::KIND_ERROR; c_err = code;
              c_have = 1'b1; c_iserr = 1'b1; ph_nxt = wpd_pkg::PH_HALT;
            end else begin
              c_kind = wpd_pkg::KIND_REPORT; c_have = 1'b1;
              c_rate = rate_r; c_ch = ch_r;
              c_div = 1'b1; c_sel_frames = 1'b1;
              c_num = chunk_nxt;
              c_den = {ch_r[DEN_W-2:0], 1'b0};
              dleft_nxt = chunk_nxt; sum_nxt = '0; idx_nxt = '0;
              ph_nxt = (chunk_nxt != 32'd0) ? wpd_pkg::PH_DATA : wpd_pkg::PH_DONE;
            end
          end else begin
            ph_nxt = (chunk_nxt != 32'd0) ? wpd_pkg::PH_SKIP : wpd_pkg::PH_ID;
          end
        end
      end
      wpd_pkg::PH_FMT: begin
        case (fbc_r)
          5'd0:    fmt_nxt[7:0]    = fmt_r[7:0]    | byte_r;
          5'd1:    fmt_nxt[15:8]   = fmt_r[15:8]   | byte_r;
          5'd2:    ch_nxt[7:0]     = ch_r[7:0]     | byte_r;
          5'd3:    ch_nxt[15:8]    = ch_r[15:8]    | byte_r;
          5'd4:    rate_nxt[7:0]   = rate_r[7:0]   | byte_r;
          5'd5:    rate_nxt[15:8]  = rate_r[15:8]  | byte_r;
          5'd6:    rate_nxt[23:16] = rate_r[23:16] | byte_r;
          5'd7:    rate_nxt[31:24] = rate_r[31:24] | byte_r;
          5'd14:   bits_nxt[7:0]   = bits_r[7:0]   | byte_r;
          5'd15:   bits_nxt[15:8]  = bits_r[15:8]  | byte_r;
          default: ;
        endcase
        fbc_nxt = fbc_inc;
        if (fbc_inc >= 5'd16) begin
          fbc_nxt = '0;
          if (fmt_nxt != wpd_pkg::FMT_PCM) begin
            c_kind = wpd_pkg::KIND_ERROR; c_err = wpd_pkg::ERR_NOT_PCM;
            c_have = 1'b1; c_iserr = 1'b1; ph_nxt = wpd_pkg::PH_HALT;
          end else begin
            found_nxt = 1'b1;
            chunk_nxt = (chunk_r > wpd_pkg::FMT_FIELD_N) ?
                        chunk_r - wpd_pkg::FMT_FIELD_N : 32'd0;
            ph_nxt = (chunk_nxt != 32'd0) ? wpd_pkg::PH_SKIP : wpd_pkg::PH_ID;
          end
        end
      end
      wpd_pkg::PH_SKIP: begin
        chunk_nxt = chunk_r - 32'd1;
        if (chunk_nxt == 32'd0) ph_nxt = wpd_pkg::PH_ID;
      end
      wpd_pkg::PH_DATA: begin
        dleft_nxt = dleft_r - 32'd1;
        if (fbc_r == 5'd0) begin
          low_nxt = byte_r;
          fbc_nxt = 5'd1;
        end else begin
          fbc_nxt = '0;
          sum_nxt = sum_new;
          idx_nxt = idx_new;
          if (idx_new >= ch_r) begin
            c_kind = wpd_pkg::KIND_SAMPLE; c_have = 1'b1;
            c_div = 1'b1; c_neg = sum_new[SUM_W-1];
            c_num = 32'(unsigned'(sum_mag));
            c_den = ch_r[DEN_W-1:0];
            c_final = (dleft_nxt < {15'd0, ch_r, 1'b0});
            sum_nxt = '0; idx_nxt = '0;
          end
        end
        if (dleft_nxt == 32'd0) begin
          if (!c_have) begin
            c_kind = wpd_pkg::KIND_END; c_have = 1'b1;
          end
          ph_nxt = wpd_pkg::PH_DONE;
        end
      end
      default: ;
    endcase

    if (eof_r) begin
      if (!c_iserr) begin
        code_ok = 1'b1;
        case (ph_nxt)
          wpd_pkg::PH_RIFF: code = wpd_pkg::ERR_NO_RIFF;
          wpd_pkg::PH_SIZE, wpd_pkg::PH_WAVE: code = wpd_pkg::ERR_NO_WAVE;
          wpd_pkg::PH_ID, wpd_pkg::PH_CSIZE, wpd_pkg::PH_FMT,
          wpd_pkg::PH_SKIP: code = wpd_pkg::ERR_MISSING;
          wpd_pkg::PH_DATA: code = wpd_pkg::ERR_TRUNC;
          default: code_ok = 1'b0;
        endcase
        if (code_ok) begin
          c_kind = wpd_pkg::KIND_ERROR; c_err = code; c_have = 1'b1;
          c_div = 1'b0; c_neg = 1'b0; c_sel_frames = 1'b0; c_final = 1'b0;
          c_rate = '0; c_ch = '0;
        end
      end
      ph_nxt = wpd_pkg::PH_RIFF; fbc_nxt = '0; tag_nxt = '0; chunk_nxt = '0;
      fmt_nxt = '0; ch_nxt = '0; rate_nxt = '0; bits_nxt = '0; found_nxt = 1'b0;
      dleft_nxt = '0; idx_nxt = '0; sum_nxt = '0; low_nxt = '0;
    end
  end

  assign need_div = c_div;
  assign div_num  = c_num;
  assign div_den  = c_den;
  assign have     = have_r;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_r <= in_byte;
      eof_r  <= in_eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= wpd_pkg::PH_RIFF; fbc_r <= '0; tag_r <= '0; chunk_r <= '0;
      fmt_r <= '0; ch_r <= '0; rate_r <= '0; bits_r <= '0; found_r <= 1'b0;
      dleft_r <= '0; idx_r <= '0; sum_r <= '0; low_r <= '0; have_r <= 1'b0;
    end else if (cmd.step) begin
      ph_r <= ph_nxt; fbc_r <= fbc_nxt; tag_r <= tag_nxt; chunk_r <= chunk_nxt;
      fmt_r <= fmt_nxt; ch_r <= ch_nxt; rate_r <= rate_nxt; bits_r <= bits_nxt;
      found_r <= found_nxt; dleft_r <= dleft_nxt; idx_r <= idx_nxt;
      sum_r <= sum_nxt; low_r <= low_nxt; have_r <= c_have;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      kind_r <= c_kind; err_r <= c_err; rate_res_r <= c_rate; ch_res_r <= c_ch;
      final_r <= c_final; neg_r <= c_neg; sel_frames_r <= c_sel_frames;
      mono_r <= '0; frames_r <= '0;
    end else if (cmd.load_q) begin
      if (sel_frames_r) begin
        frames_r <= div_quo[30:0];
      end else begin
        mono_r <= neg_r ? -div_quo[15:0] : div_quo[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_kind <= kind_r; o_mono <= mono_r; o_rate <= rate_res_r;
      o_ch <= ch_res_r; o_frames <= frames_r; o_err <= err_r; o_final <= final_r;
    end
  end

endmodule
`default_nettype wire

// ===== src/wav_pcm16_parse_downmix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wav_pcm16_parse_downmix
// Byte-stream RIFF/WAVE PCM16 parser with mono downmix of each frame.
//
//   channel  direction  tdata                                       tuser  tlast
//   in_      slave      [7:0] file_byte                             -      end_of_file
//   out_     master     mono,rate,channels,frames,error (104 bits)  kind   final_sample
//
// Each byte passes through the step and output states before the next byte is
// taken; any result it has is registered in the output state. A byte that ends a
// frame or a valid data chunk header also waits on the 32-step divider between them.
// Synchronous active-low reset returns the parser to the RIFF tag.
// A pending result holds the output register; the next byte is taken, its
// result waits until the output transfer completes, and input stalls meanwhile.
// ----------------------------------------------------------------------------
module wav_pcm16_parse_downmix #(
  parameter int MAX_CHANNELS = wpd_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] file_byte
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [15:0] mono_sample, [47:16] rate_hz, [63:48] channel_count,
  // [94:64] frames_total, [97:95] error_code, [103:98] zero
  output logic [103:0]      out_tdata,
  output logic [1:0]        out_tuser,  // [1:0] result_kind
  output logic              out_tlast
);

  localparam int DEN_W = $clog2(MAX_CHANNELS) + 2;

  wpd_pkg::cmd_t    cmd;
  wpd_pkg::status_t sts;
  logic                      need_div, have, div_done;
  logic [wpd_pkg::NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0]          div_den;
  logic [15:0]               o_mono, o_ch;
  logic [31:0]               o_rate;
  logic [30:0]               o_frames;
  logic [2:0]                o_err;

  assign sts.need_div = need_div;
  assign sts.have     = have;
  assign sts.div_done = div_done;

  wpd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  wpd_div #(.DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  wpd_datapath #(.MAX_CHANNELS(MAX_CHANNELS), .DEN_W(DEN_W)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_tvalid && in_tready),
    .in_byte   (in_tdata),
    .in_eof    (in_tlast),
    .cmd       (cmd),
    .need_div  (need_div),
    .have      (have),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_quo   (div_quo),
    .o_kind    (out_tuser),
    .o_mono    (o_mono),
    .o_rate    (o_rate),
    .o_ch      (o_ch),
    .o_frames  (o_frames),
    .o_err     (o_err),
    .o_final   (out_tlast)
  );

  assign out_tdata = {6'd0, o_err, o_frames, o_ch, o_rate, o_mono};

endmodule
`default_nettype wire

// ===== test/wav_pcm16_parse_downmix_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_pcm16_parse_downmix_tb
// Feeds WAV byte streams (valid files, damaged headers, truncated files and
// noise) and checks every result against a built-in parser model.
// ----------------------------------------------------------------------------
module wav_pcm16_parse_downmix_tb;

  localparam int MAXCH = wpd_pkg::MAX_CHANNELS_DEF;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] mono;
    logic [31:0] rate;
    logic [15:0] chans;
    logic [30:0] frames;
    logic [2:0]  err;
    logic        fin;
  } wav_result_t;

  class wav_scoreboard;
    wav_result_t pending[$];
    int errors;
    logic [3:0]  ph;
    logic [4:0]  fcnt;
    logic [31:0] tags, csize, rate_v, dleft;
    logic [15:0] fmt_v, ch_v, bits_v, chidx;
    logic        fmt_ok;
    int          sum;
    logic [7:0]  lowb;

    function void clear();
      ph = wpd_pkg::PH_RIFF; fcnt = 0; tags = 0; csize = 0; fmt_v = 0; ch_v = 0;
      rate_v = 0; bits_v = 0; fmt_ok = 0; dleft = 0; chidx = 0; sum = 0;
      lowb = 0;
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      wav_result_t r;
      logic have, is_err;
      logic [2:0] code;
      logic [15:0] v;
      int s, mean, k;
      r = '0; have = 0; is_err = 0;
      case (ph)
        wpd_pkg::PH_RIFF, wpd_pkg::PH_WAVE, wpd_pkg::PH_ID: begin
          tags = {tags[23:0], b};
          fcnt++;
          if (fcnt >= 4) begin
            fcnt = 0;
            if (ph == wpd_pkg::PH_ID) begin
              csize = 0; ph = wpd_pkg::PH_CSIZE;
            end else if (ph == wpd_pkg::PH_RIFF) begin
              if (tags != wpd_pkg::TAG_RIFF) begin
                r.kind = wpd_pkg::KIND_ERROR; r.err = wpd_pkg::ERR_NO_RIFF;
                have = 1; is_err = 1; ph = wpd_pkg::PH_HALT;
              end else ph = wpd_pkg::PH_SIZE;
            end else begin
              if (tags != wpd_pkg::TAG_WAVE) begin
                r.kind = wpd_pkg::KIND_ERROR; r.err = wpd_pkg::ERR_NO_WAVE;
                have = 1; is_err = 1; ph = wpd_pkg::PH_HALT;
              end else ph = wpd_pkg::PH_ID;
            end
          end
        end
        wpd_pkg::PH_SIZE: begin
          fcnt++;
          if (fcnt >= 4) begin fcnt = 0; ph = wpd_pkg::PH_WAVE; end
        end
        wpd_pkg::PH_CSIZE: begin
          csize = csize | (32'(b) << (8 * fcnt[1:0]));
          fcnt++;
          if (fcnt >= 4) begin
            fcnt = 0;
            if (tags == wpd_pkg::TAG_FMT) begin
              fmt_v = 0; ch_v = 0; rate_v = 0; bits_v = 0; ph = wpd_pkg::PH_FMT;
            end else if (tags == wpd_pkg::TAG_DATA) begin
              have = 1;
              if (!fmt_ok) code = wpd_pkg::ERR_MISSING;
              else if (bits_v != wpd_pkg::BITS_16) code = wpd_pkg::ERR_NOT_16BIT;
              else if (ch_v == 0) code = wpd_pkg::ERR_ZERO_CH;
              else if (ch_v > MAXCH) code = wpd_pkg::ERR_MANY_CH;
              else code = 3'bx;
              if (ch_v == 0 || !fmt_ok || bits_v != wpd_pkg::BITS_16 || ch_v > MAXCH) begin
                r.kind = wpd_pkg::KIND_ERROR; r.err = code; is_err = 1;
                ph = wpd_pkg::PH_HALT;
              end else begin
                r.kind = wpd_pkg::KIND_REPORT; r.rate = rate_v; r.chans = ch_v;
                r.frames = 31'(csize / (32'd2 * ch_v));
                dleft = csize; sum = 0; chidx = 0;
                ph = (dleft != 0) ? wpd_pkg::PH_DATA : wpd_pkg::PH_DONE;
              end
            end else ph = (csize != 0) ? wpd_pkg::PH_SKIP : wpd_pkg::PH_ID;
          end
        end
        wpd_pkg::PH_FMT: begin
          k = int'(fcnt);
          if (k < 2) fmt_v[8*k +: 8] = b;
          else if (k < 4) ch_v[8*(k-2) +: 8] = b;
          else if (k < 8) rate_v[8*(k-4) +: 8] = b;
          else if (k >= 14 && k < 16) bits_v[8*(k-14) +: 8] = b;
          fcnt++;
          if (fcnt >= 16) begin
            fcnt = 0;
            if (fmt_v != wpd_pkg::FMT_PCM) begin
              r.kind = wpd_pkg::KIND_ERROR; r.err = wpd_pkg::ERR_NOT_PCM;
              have = 1; is_err = 1; ph = wpd_pkg::PH_HALT;
            end else begin
              fmt_ok = 1;
              csize = (csize > 16) ? csize - 16 : 0;
              ph = (csize != 0) ? wpd_pkg::PH_SKIP : wpd_pkg::PH_ID;
            end
          end
        end
        wpd_pkg::PH_SKIP: begin
          csize--;
          if (csize == 0) ph = wpd_pkg::PH_ID;
        end
        wpd_pkg::PH_DATA: begin
          dleft--;
          if (fcnt == 0) begin
            lowb = b; fcnt = 1;
          end else begin
            v = {b, lowb};
            s = $signed(v);
            fcnt = 0;
            sum += s;
            chidx++;
            if (chidx >= ch_v) begin
              mean = sum / int'(ch_v);
              r.kind = wpd_pkg::KIND_SAMPLE; r.mono = mean[15:0];
              r.fin = (dleft < 32'd2 * ch_v);
              have = 1; sum = 0; chidx = 0;
            end
          end
          if (dleft == 0) begin
            if (!have) begin r.kind = wpd_pkg::KIND_END; have = 1; end
            ph = wpd_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
      if (eof) begin
        if (!is_err && ph != wpd_pkg::PH_HALT && ph != wpd_pkg::PH_DONE) begin
          r = '0; r.kind = wpd_pkg::KIND_ERROR; have = 1;
          if (ph == wpd_pkg::PH_RIFF) r.err = wpd_pkg::ERR_NO_RIFF;
          else if (ph == wpd_pkg::PH_SIZE || ph == wpd_pkg::PH_WAVE)
            r.err = wpd_pkg::ERR_NO_WAVE;
          else if (ph == wpd_pkg::PH_DATA) r.err = wpd_pkg::ERR_TRUNC;
          else r.err = wpd_pkg::ERR_MISSING;
        end
        clear();
      end
      if (have) pending.push_back(r);
    endfunction

    task report_mismatch(string what, wav_result_t e, wav_result_t g);
      errors++;
      $display("MISMATCH %s: expected %h got %h", what, e, g);
    endtask

    task check_result(wav_result_t got);
      wav_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", 0, got);
        return;
      end
      e = pending.pop_front();
      if (got.kind != e.kind) report_mismatch("kind", e, got);
      if (got.mono != e.mono) report_mismatch("mono_sample", e, got);
      if (got.rate != e.rate) report_mismatch("rate_hz", e, got);
      if (got.chans != e.chans) report_mismatch("channel_count", e, got);
      if (got.frames != e.frames) report_mismatch("frames_total", e, got);
      if (got.err != e.err) report_mismatch("error_code", e, got);
      if (got.fin != e.fin) report_mismatch("final_sample", e, got);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tlast = 0, out_tready = 0;
  logic [7:0] in_tdata = 0;
  logic out_tvalid, in_tready, out_tlast;
  logic [103:0] out_tdata;
  logic [1:0] out_tuser;

  wav_scoreboard sb;
  logic [7:0] fbytes[$];
  logic       flast[$];
  bit hold_off = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  wav_pcm16_parse_downmix uut (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  task automatic put_byte(logic [7:0] b);
    fbytes.push_back(b); flast.push_back(0);
  endtask

  task automatic put_word(logic [31:0] w, int n);
    for (int i = 0; i < n; i++) put_byte(w[8*i +: 8]);
  endtask

  task automatic put_tag(logic [31:0] t);
    for (int i = 3; i >= 0; i--) put_byte(t[8*i +: 8]);
  endtask

  task automatic end_file();
    if (flast.size() == 0) put_byte(8'($urandom));
    flast[flast.size()-1] = 1;
  endtask

  task automatic put_fmt(logic [15:0] fmt, logic [15:0] ch, logic [31:0] rate,
                         logic [15:0] bits, logic [31:0] sz);
    put_tag(wpd_pkg::TAG_FMT); put_word(sz, 4);
    put_word(32'(fmt), 2); put_word(32'(ch), 2); put_word(rate, 4);
    put_word($urandom, 4); put_word($urandom, 2); put_word(32'(bits), 2);
    for (int i = 16; i < sz; i++) put_byte(8'($urandom));
  endtask

  task automatic put_sample(int mode);
    logic [15:0] s;
    case (mode)
      0: s = 16'h8000;
      1: s = 16'h7FFF;
      2: s = 16'hFFFF;
      default: s = 16'($urandom);
    endcase
    put_word(32'(s), 2);
  endtask

  task automatic build_file(int variant, int ch, int frames, int extra);
    int n;
    put_tag(wpd_pkg::TAG_RIFF); put_word($urandom, 4); put_tag(wpd_pkg::TAG_WAVE);
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(0, 5);
      put_tag($urandom); put_word(n, 4);
      for (int i = 0; i < n; i++) put_byte(8'($urandom));
    end
    put_fmt(variant == 1 ? 16'd3 : wpd_pkg::FMT_PCM, 16'(ch), $urandom,
            variant == 2 ? 16'd24 : wpd_pkg::BITS_16,
            32'(16 + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : 0)));
    n = 2 * ch * frames + extra;
    put_tag(wpd_pkg::TAG_DATA); put_word(n, 4);
    for (int i = 0; i < n / 2; i++) put_sample($urandom_range(0, 5));
    if (n % 2) put_byte(8'($urandom));
    if (variant == 3) begin
      repeat ($urandom_range(1, 4)) begin
        void'(fbytes.pop_back());
        void'(flast.pop_back());
      end
    end else if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
    end
    end_file();
  endtask

  task automatic build_directed();
    put_tag(32'h52494647); end_file();                  // bad RIFF
    put_tag(wpd_pkg::TAG_RIFF); put_word(0, 4); put_tag(32'h57415646); end_file();
    put_byte(8'h52); end_file();                         // early end in tag
    put_tag(wpd_pkg::TAG_RIFF); put_byte(0); end_file(); // early end in size
    put_tag(wpd_pkg::TAG_RIFF); put_word(0, 4); put_tag(wpd_pkg::TAG_WAVE);
    put_tag(wpd_pkg::TAG_DATA); put_word(4, 4); end_file();  // no fmt
    put_tag(wpd_pkg::TAG_RIFF); put_word(0, 4); put_tag(wpd_pkg::TAG_WAVE);
    put_fmt(wpd_pkg::FMT_PCM, 0, 1, wpd_pkg::BITS_16, 16);
    put_tag(wpd_pkg::TAG_DATA); put_word(2, 4); end_file();
    put_tag(wpd_pkg::TAG_RIFF); put_word(0, 4); put_tag(wpd_pkg::TAG_WAVE);
    put_fmt(wpd_pkg::FMT_PCM, 9, 1, wpd_pkg::BITS_16, 4);
    put_tag(wpd_pkg::TAG_DATA); put_word(2, 4); end_file();
    put_tag(wpd_pkg::TAG_RIFF); put_word(0, 4); put_tag(wpd_pkg::TAG_WAVE);
    put_fmt(wpd_pkg::FMT_PCM, 2, 32'hFFFFFFFF, 16'd8, 16);
    put_tag(wpd_pkg::TAG_DATA); put_word(2, 4); end_file();
    put_tag(wpd_pkg::TAG_RIFF); put_word(0, 4); put_tag(wpd_pkg::TAG_WAVE);
    put_fmt(wpd_pkg::FMT_PCM, 1, 8000, wpd_pkg::BITS_16, 16);
    put_fmt(wpd_pkg::FMT_PCM, 2, 44100, wpd_pkg::BITS_16, 18);
    put_tag(wpd_pkg::TAG_DATA); put_word(0, 4); put_byte(8'hAA); end_file();  // empty data
    put_tag(wpd_pkg::TAG_RIFF); put_word(0, 4); put_tag(wpd_pkg::TAG_WAVE);
    put_fmt(wpd_pkg::FMT_PCM, 3, 0, wpd_pkg::BITS_16, 16);
    put_tag(wpd_pkg::TAG_DATA); put_word(32'hFFFFFFFF, 4);
    for (int i = 0; i < 3; i++) put_sample(0);
    for (int i = 0; i < 3; i++) put_sample(1);
    put_sample(2); put_sample(2); put_byte(8'h00); end_file();  // truncated on frame
    build_file(1, 2, 1, 0);
    build_file(0, 8, 2, 0);
    build_file(0, 2, 2, 3);                              // partial frame
    build_file(0, 1, 3, 1);
  endtask

  task automatic send_all();
    int w;
    while (fbytes.size() > 0) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
      if (w > 0) begin
        in_tvalid <= 0;
        repeat (w) @(posedge clk);
      end
      in_tvalid <= 1;
      in_tdata <= fbytes.pop_front();
      in_tlast <= flast.pop_front();
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 0;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tuser, out_tdata[15:0], out_tdata[47:16], out_tdata[63:48],
                       out_tdata[94:64], out_tdata[97:95], out_tlast});
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("wav_pcm16_parse_downmix test failed");
      $finish;
    end
  end

  initial begin : receiver
    int w;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 0;
        @(posedge clk);
      end else begin
        w = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0;
        out_tready <= (w == 0);
        repeat (w) @(posedge clk);
        out_tready <= 1;
        @(posedge clk);
      end
    end
  end

  initial begin : stall_stretch
    @(posedge rst_n);
    repeat (3000) @(posedge clk);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  initial begin : main
    int count;
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    build_directed();
    send_all();
    count = 0;
    while (count < 2000) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
          if ($urandom_range(0, 1)) end_file();
          else begin fbytes.delete(); flast.delete(); continue; end
        end
        1: build_file($urandom_range(1, 3), $urandom_range(1, 4), $urandom_range(1, 4), 0);
        default: build_file(0, $urandom_range(1, MAXCH), $urandom_range(0, 6),
                            $urandom_range(0, 4) == 0 ? $urandom_range(1, 3) : 0);
      endcase
      count += fbytes.size();
      send_all();
    end
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("wav_pcm16_parse_downmix test passed");
    else $display("wav_pcm16_parse_downmix test failed");
    $finish;
  end
endmodule

// ===== files.f =====
src/wpd_pkg.sv
src/wpd_div.sv
src/wpd_ctrl.sv
src/wpd_datapath.sv
src/wav_pcm16_parse_downmix.sv
test/wav_pcm16_parse_downmix_tb.sv
